// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the keypad qualifier RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the synchronous reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ----- rtl/kprq_pkg.sv -----
// Package for the keypad press/repeat qualifier: field widths, register
// indexes, reset values and the result record. No dependencies.
`default_nettype none

package kprq_pkg;

    localparam int KEY_FIELD_W = 16;
    localparam int TICK_W      = 32;
    localparam int INDEX_W     = 4;
    localparam int FRAMES_W    = 8;
    localparam int CFG_IDX_W   = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_REPEAT  = 8'd1;

    // Register values after reset.
    localparam logic [FRAMES_W-1:0] FIRST_REPEAT_RST = 8'd20;
    localparam logic [FRAMES_W-1:0] NEXT_REPEAT_RST  = 8'd5;

    // Packed tdata widths (whole bytes).
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic                   key_pressed;
        logic [INDEX_W-1:0]     key_index;
        logic [KEY_FIELD_W-1:0] free_held_keys;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/kprq_lowbit.sv -----
// Lowest-set-bit isolator and position encoder for a key mask.
// Depends on kprq_pkg for the index width.
`default_nettype none

module kprq_lowbit #(
    parameter int W = 16
) (
    input  wire logic [W-1:0]                 i_vec,
    output logic      [W-1:0]                 o_onehot,
    output logic      [kprq_pkg::INDEX_W-1:0] o_index
);

    // Two's complement trick keeps only the lowest set bit.
    assign o_onehot = i_vec & ((~i_vec) + W'(1));

    // Positions above 15 wrap to four bits, as the index field allows.
    always_comb begin
        o_index = '0;
        for (int i = 0; i < W; i++) begin
            if (o_onehot[i]) begin
                o_index = o_index | kprq_pkg::INDEX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/kprq_step.sv -----
// Per-frame key state and press/repeat decision for one frame item.
// Depends on kprq_pkg, kprq_lowbit and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kprq_step #(
    parameter int NUM_KEYS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire logic [kprq_pkg::KEY_FIELD_W-1:0]  i_held,
    input  wire logic [kprq_pkg::TICK_W-1:0]       i_tick,
    input  wire logic                              i_wait,
    input  wire logic [kprq_pkg::FRAMES_W-1:0]     i_first_frames,
    input  wire logic [kprq_pkg::FRAMES_W-1:0]     i_next_frames,
    output kprq_pkg::t_result                      o_res
);

    // Only keys that exist and fit in the held field carry information.
    localparam int CW = (NUM_KEYS < kprq_pkg::KEY_FIELD_W) ? NUM_KEYS
                                                           : kprq_pkg::KEY_FIELD_W;

    logic [NUM_KEYS-1:0]             r_cur, r_lock, r_rep;
    logic [kprq_pkg::TICK_W-1:0]     r_last;
    logic [kprq_pkg::FRAMES_W-1:0]   r_span;

    logic [NUM_KEYS-1:0]             n_lock, n_rep;
    logic [kprq_pkg::TICK_W-1:0]     n_last;
    logic [kprq_pkg::FRAMES_W-1:0]   n_span;

    logic [NUM_KEYS-1:0]             cur, lock_k, rep_k, prev_w, press, fresh, valid;
    logic [NUM_KEYS-1:0]             low_onehot, free_k;
    logic [kprq_pkg::INDEX_W-1:0]    low_index;
    logic [kprq_pkg::TICK_W-1:0]     deadline;
    logic                            due, hit;

    kprq_lowbit #(.W(NUM_KEYS)) u_lowbit (
        .i_vec    (valid),
        .o_onehot (low_onehot),
        .o_index  (low_index)
    );

    always_comb begin
        cur    = NUM_KEYS'(i_held[CW-1:0]);
        // A key that changed state loses its lock and its repeat mark.
        lock_k = r_lock & ~(r_cur ^ cur);
        rep_k  = r_rep & lock_k;

        deadline = r_last + kprq_pkg::TICK_W'(r_span);
        due      = (i_tick >= deadline);

        // A due repeat makes the repeating key look newly pressed.
        prev_w = (i_wait && due) ? (r_cur & ~rep_k) : r_cur;
        press  = cur & ~prev_w;
        fresh  = press & ~rep_k;
        valid  = (|fresh) ? fresh : rep_k;
        hit    = i_wait && (|press);

        n_lock = hit ? (lock_k | valid) : lock_k;
        n_rep  = hit ? low_onehot : rep_k;
        n_last = hit ? i_tick : r_last;
        n_span = r_span;
        if (hit) begin
            n_span = (valid != rep_k) ? i_first_frames : i_next_frames;
        end

        free_k = cur & ~n_lock;

        o_res.key_pressed    = hit;
        o_res.key_index      = hit ? low_index : '0;
        o_res.free_held_keys = kprq_pkg::KEY_FIELD_W'(free_k[CW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_lock <= '0;
            r_rep  <= '0;
            r_last <= '0;
            r_span <= '0;
        end else if (i_fire) begin
            r_cur  <= cur;
            r_lock <= n_lock;
            r_rep  <= n_rep;
            r_last <= n_last;
            r_span <= n_span;
        end
    end

    `ASSERT_CLK(a_rep_onehot, i_clk, i_rst_n, $onehot0(r_rep), "repeat mark not one-hot")
    `ASSERT_NEVER(a_rep_locked, i_clk, i_rst_n, (r_rep & ~r_lock) != '0,
                  "repeat key is not locked")
    `ASSERT_CLK(a_press_tick, i_clk, i_rst_n,
                i_rst_n && i_fire && o_res.key_pressed |=> r_last == $past(i_tick),
                "press did not record its tick")

endmodule

`default_nettype wire

// ----- rtl/keypad_press_repeat_qualifier.sv -----
// Keypad press/repeat qualifier: one request per frame in, one result out.
// A request is captured in the input register, and its result then in the
// result register. Throughput: one request per cycle while the result
// side is not stalled. Synchronous active-low reset clears the key state
// and the valid flags and restores the repeat delays to 20 and 5 frames.
`default_nettype none
`include "assert_macros.svh"

module keypad_press_repeat_qualifier #(
    parameter int NUM_KEYS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata, low bit up: held_keys[15:0], frame_tick[47:16],
    // wait_for_key[48], zero fill [55:49].
    input  wire logic [kprq_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata, low bit up: key_pressed[0], key_index[4:1],
    // free_held_keys[20:5], zero fill [23:21].
    output logic      [kprq_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write channel.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [kprq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kprq_pkg::FRAMES_W-1:0]     i_cfg_data
);

    // Repeat timing registers. Writes are always taken; they are expected
    // only while the block is idle.
    logic [kprq_pkg::FRAMES_W-1:0] r_first_frames, r_next_frames;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_frames <= kprq_pkg::FIRST_REPEAT_RST;
            r_next_frames  <= kprq_pkg::NEXT_REPEAT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kprq_pkg::CFG_FIRST_REPEAT: r_first_frames <= i_cfg_data;
                kprq_pkg::CFG_NEXT_REPEAT:  r_next_frames  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register. The request in it is processed in the cycle that the
    // result register can take its outcome; the state updates at that edge.
    logic                                r_in_vld;
    logic [kprq_pkg::KEY_FIELD_W-1:0]    r_held;
    logic [kprq_pkg::TICK_W-1:0]         r_tick;
    logic                                r_wait;

    // Result register, which lets a new request enter while a result waits.
    logic                                r_out_vld;
    kprq_pkg::t_result                   r_res;

    logic                                s_acc, advance, fire;
    kprq_pkg::t_result                   step_res;

    assign advance  = !r_out_vld || m_tready;
    assign fire     = r_in_vld && advance;
    assign s_tready = !r_in_vld || advance;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= s_acc || (r_in_vld && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_held <= s_tdata[15:0];
            r_tick <= s_tdata[47:16];
            r_wait <= s_tdata[48];
        end
    end

    kprq_step #(.NUM_KEYS(NUM_KEYS)) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_held         (r_held),
        .i_tick         (r_tick),
        .i_wait         (r_wait),
        .i_first_frames (r_first_frames),
        .i_next_frames  (r_next_frames),
        .o_res          (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= step_res;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {3'b000, r_res.free_held_keys, r_res.key_index, r_res.key_pressed};

    // A waiting result must survive a stall.
    `ASSERT_CLK(a_out_held, i_clk, i_rst_n,
                i_rst_n && r_out_vld && !m_tready |=> r_out_vld,
                "stalled result was dropped")
    // A waiting result keeps its contents until it is taken.
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n,
                i_rst_n && r_out_vld && !m_tready |=> $stable(r_res),
                "stalled result changed")
    // The index field is zero whenever no press is reported.
    `ASSERT_NEVER(a_idx_zero, i_clk, i_rst_n,
                  r_out_vld && !r_res.key_pressed && (r_res.key_index != '0),
                  "key index set without a press")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the keypad press/repeat qualifier.
// Depends on kprq_pkg and the keypad_press_repeat_qualifier top level; it
// drives frame requests and register writes and scoreboards every result.
`timescale 1ns / 100ps

module tb_top;

    // The block is built with 16 keys, so every held bit is a live key.
    localparam int NUM_KEYS = 16;

    // A register index past the two real registers; writes to it are ignored.
    localparam logic [kprq_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd2;

    // Cycles without any accepted request on any channel before giving up.
    localparam int STALL_LIMIT = 5000;

    // Random stimulus per stall profile.
    localparam int FRAMES_PER_PHASE = 200;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               s_tvalid    = 1'b0;
    logic                               s_tready;
    logic [kprq_pkg::S_TDATA_W-1:0]     s_tdata     = '0;
    logic                               m_tvalid;
    logic                               m_tready    = 1'b0;
    logic [kprq_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [kprq_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [kprq_pkg::FRAMES_W-1:0]      i_cfg_data  = '0;

    // Percent of cycles in which the frame source or the result sink idles.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    int error_count    = 0;
    int frames_sent    = 0;
    int results_seen   = 0;
    int presses_seen   = 0;
    int cfg_writes     = 0;
    int stall_cycles   = 0;

    // Results predicted at input acceptance, oldest first.
    kprq_pkg::t_result pending_results[$];

    // Shadow copy of the qualifier's registers and key state.
    logic [kprq_pkg::FRAMES_W-1:0]    first_delay_q;
    logic [kprq_pkg::FRAMES_W-1:0]    next_delay_q;
    logic [NUM_KEYS-1:0]              prev_keys_q;
    logic [NUM_KEYS-1:0]              cur_keys_q;
    logic [NUM_KEYS-1:0]              rep_key_q;
    logic [NUM_KEYS-1:0]              lock_q;
    logic [kprq_pkg::TICK_W-1:0]      last_tick_q;
    logic [kprq_pkg::FRAMES_W-1:0]    span_q;

    keypad_press_repeat_qualifier #(
        .NUM_KEYS(NUM_KEYS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advances the shadow key state by one frame and returns the result the
    // block must produce for it. The repeat deadline wraps at 32 bits and is
    // compared unsigned, exactly as the hardware does.
    function automatic kprq_pkg::t_result predict_frame(
                                              logic [NUM_KEYS-1:0] held,
                                              logic [kprq_pkg::TICK_W-1:0] tick,
                                              logic waiting);
        kprq_pkg::t_result             res;
        logic [NUM_KEYS-1:0]           press;
        logic [NUM_KEYS-1:0]           fresh;
        logic [NUM_KEYS-1:0]           valid;
        logic [kprq_pkg::TICK_W-1:0]   deadline;
        res = '0;
        prev_keys_q = cur_keys_q;
        cur_keys_q  = held;
        // Any key that changed state loses its lock and its repeat mark.
        lock_q    &= ~(prev_keys_q ^ cur_keys_q);
        rep_key_q &= lock_q;
        if (waiting) begin
            deadline = last_tick_q + kprq_pkg::TICK_W'(span_q);
            // A due repeat makes the repeating key look newly pressed.
            if (tick >= deadline) begin
                prev_keys_q &= ~rep_key_q;
            end
            press = cur_keys_q & ~prev_keys_q;
            if (press != '0) begin
                fresh = press & ~rep_key_q;
                valid = (fresh != '0) ? fresh : rep_key_q;
                lock_q |= valid;
                last_tick_q = tick;
                span_q = (valid != rep_key_q) ? first_delay_q : next_delay_q;
                rep_key_q = valid & (~valid + 1'b1);
                res.key_pressed = 1'b1;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (rep_key_q[k]) begin
                        res.key_index = kprq_pkg::INDEX_W'(k);
                    end
                end
            end
        end
        res.free_held_keys = cur_keys_q & ~lock_q;
        return res;
    endfunction

    // Offers one frame request, with random source idling in front of it,
    // and records the expected result once the block takes it. The valid
    // stays high afterwards so back-to-back frames need no bubble.
    task automatic send_frame(input logic [kprq_pkg::KEY_FIELD_W-1:0] held,
                              input logic [kprq_pkg::TICK_W-1:0] tick,
                              input logic waiting);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, waiting, tick, held};
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_frame(held, tick, waiting));
        frames_sent++;
    endtask

    // Stops offering frames and waits until every result has come back,
    // plus the pipeline depth, so the block is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register write request; only issued while the block is idle.
    task automatic write_register(input logic [kprq_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [kprq_pkg::FRAMES_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == kprq_pkg::CFG_FIRST_REPEAT) begin
            first_delay_q = value;
        end else if (idx == kprq_pkg::CFG_NEXT_REPEAT) begin
            next_delay_q = value;
        end
        cfg_writes++;
    endtask

    // Result sink: random backpressure, and every accepted result is
    // compared field by field with the oldest prediction.
    always @(posedge i_clk) begin
        kprq_pkg::t_result got;
        kprq_pkg::t_result want;
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
        if (i_rst_n && m_tvalid && m_tready) begin
            // Fields sit in m_tdata from the lowest bit up.
            got.key_pressed    = m_tdata[0];
            got.key_index      = m_tdata[4:1];
            got.free_held_keys = m_tdata[20:5];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no pending request: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.key_pressed) begin
                    presses_seen++;
                end
                if (got.key_pressed !== want.key_pressed) begin
                    $error("key_pressed: expected %0d, got %0d",
                           want.key_pressed, got.key_pressed);
                    error_count++;
                end
                if (got.key_index !== want.key_index) begin
                    $error("key_index: expected %0d, got %0d",
                           want.key_index, got.key_index);
                    error_count++;
                end
                if (got.free_held_keys !== want.free_held_keys) begin
                    $error("free_held_keys: expected %h, got %h",
                           want.free_held_keys, got.free_held_keys);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any accepted request on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[keypad_press_repeat_qualifier] ERROR");
            $finish;
        end
    end

    // New presses, adding a key while another is held, repeats at the reset
    // delays, releases, and a repeat coming due while nothing is held.
    task automatic test_basic_presses();
        send_frame(16'h0000, 32'd0, 1'b0);
        // Held but not waiting: nothing is reported, nothing gets locked.
        send_frame(16'hFFFF, 32'd1, 1'b0);
        // Waiting, but the keys were already down last frame.
        send_frame(16'hFFFF, 32'd2, 1'b1);
        send_frame(16'h0000, 32'd3, 1'b1);
        // Highest key alone, then the lowest key joins it.
        send_frame(16'h8000, 32'd4, 1'b1);
        send_frame(16'h8001, 32'd5, 1'b1);
        // First repeat is due at last press plus the first-repeat delay.
        send_frame(16'h8001, 32'd24, 1'b1);
        send_frame(16'h8001, 32'd25, 1'b1);
        send_frame(16'h8001, 32'd30, 1'b1);
        send_frame(16'h8001, 32'd31, 1'b0);
        // Many fresh keys at once: the lowest one wins, all of them lock.
        send_frame(16'hFFFF, 32'd32, 1'b1);
        send_frame(16'h0000, 32'd33, 1'b1);
        // Deadline passed with every key up.
        send_frame(16'h0000, 32'd60, 1'b1);
    endtask

    // The deadline sum wraps past 2^32, so right after a press near the top
    // of the tick range the wrapped deadline is already behind the tick.
    task automatic test_tick_wrap();
        send_frame(16'h0004, 32'hFFFF_FFF0, 1'b1);
        send_frame(16'h0004, 32'hFFFF_FFF1, 1'b1);
        send_frame(16'h0004, 32'h0000_0002, 1'b1);
        send_frame(16'h0004, 32'hFFFF_FFFF, 1'b1);
    endtask

    // Zero delays repeat on every waiting frame; the largest delays hold off
    // until exactly 255 ticks. A write to an unused index must change nothing.
    task automatic test_register_extremes();
        write_register(kprq_pkg::CFG_FIRST_REPEAT, 8'd0);
        write_register(kprq_pkg::CFG_NEXT_REPEAT, 8'd0);
        write_register(CFG_UNUSED_IDX, 8'hFF);
        send_frame(16'h0000, 32'd99, 1'b1);
        send_frame(16'h0010, 32'd100, 1'b1);
        send_frame(16'h0010, 32'd100, 1'b1);
        send_frame(16'h0010, 32'd101, 1'b1);
        write_register(kprq_pkg::CFG_FIRST_REPEAT, 8'd255);
        write_register(kprq_pkg::CFG_NEXT_REPEAT, 8'd255);
        send_frame(16'h0000, 32'd200, 1'b1);
        send_frame(16'h0100, 32'd201, 1'b1);
        send_frame(16'h0100, 32'd455, 1'b1);
        send_frame(16'h0100, 32'd456, 1'b1);
    endtask

    // Frame streams shaped like real use: the tick mostly steps by one, key
    // masks are held for runs of frames so repeats come due, and a few
    // frames carry random masks, frozen ticks or jumps as noise.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [kprq_pkg::FRAMES_W-1:0] first_val,
                                       input logic [kprq_pkg::FRAMES_W-1:0] next_val,
                                       input int num_frames);
        logic [kprq_pkg::KEY_FIELD_W-1:0] hold_mask;
        logic [kprq_pkg::KEY_FIELD_W-1:0] frame_mask;
        logic [kprq_pkg::TICK_W-1:0]      tick_now;
        logic                             waiting;
        int                               run_left;
        int                               pick;
        write_register(kprq_pkg::CFG_FIRST_REPEAT, first_val);
        write_register(kprq_pkg::CFG_NEXT_REPEAT, next_val);
        write_register(kprq_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                       kprq_pkg::FRAMES_W'($urandom));
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        hold_mask = '0;
        run_left  = 0;
        // Start near the wrap point in about a third of the phases.
        if ($urandom_range(2) == 0) begin
            tick_now = 32'hFFFF_FF00 + $urandom_range(255);
        end else begin
            tick_now = $urandom;
        end
        for (int n = 0; n < num_frames; n++) begin
            if (run_left == 0) begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    hold_mask = '0;
                end else if (pick < 50) begin
                    hold_mask = kprq_pkg::KEY_FIELD_W'(1) << $urandom_range(15);
                end else if (pick < 70) begin
                    // Another key goes down while the current ones stay held.
                    hold_mask |= kprq_pkg::KEY_FIELD_W'(1) << $urandom_range(15);
                end else if (pick < 88) begin
                    hold_mask = (kprq_pkg::KEY_FIELD_W'(1) << $urandom_range(15)) |
                                (kprq_pkg::KEY_FIELD_W'(1) << $urandom_range(15));
                end else begin
                    hold_mask = kprq_pkg::KEY_FIELD_W'($urandom);
                end
                run_left = $urandom_range(1, 30);
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 90) begin
                tick_now = tick_now + 1;
            end else if (pick < 95) begin
                tick_now = $urandom;
            end
            frame_mask = ($urandom_range(99) < 5) ? kprq_pkg::KEY_FIELD_W'($urandom)
                                                  : hold_mask;
            waiting = ($urandom_range(99) < 85);
            send_frame(frame_mask, tick_now, waiting);
        end
    endtask

    initial begin
        // Shadow state matches the block after reset.
        first_delay_q = kprq_pkg::FIRST_REPEAT_RST;
        next_delay_q  = kprq_pkg::NEXT_REPEAT_RST;
        prev_keys_q   = '0;
        cur_keys_q    = '0;
        rep_key_q     = '0;
        lock_q        = '0;
        last_tick_q   = '0;
        span_q        = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks run under the first stall profile.
        src_idle_pct  = 6;
        sink_idle_pct = 71;
        test_basic_presses();
        test_tick_wrap();
        test_register_extremes();

        // Short delays first so repeats are frequent, then longer ones, then
        // the reset delays restored with both sides running flat out.
        test_random_traffic(6, 71, kprq_pkg::FRAMES_W'($urandom_range(0, 12)),
                            kprq_pkg::FRAMES_W'($urandom_range(0, 6)), FRAMES_PER_PHASE);
        test_random_traffic(71, 6, kprq_pkg::FRAMES_W'($urandom_range(10, 40)),
                            kprq_pkg::FRAMES_W'($urandom_range(1, 8)), FRAMES_PER_PHASE);
        test_random_traffic(0, 0, kprq_pkg::FIRST_REPEAT_RST, kprq_pkg::NEXT_REPEAT_RST,
                            FRAMES_PER_PHASE);

        wait_idle();
        $display("Run covered %0d frames, %0d results (%0d key presses), %0d register writes,",
                 frames_sent, results_seen, presses_seen, cfg_writes);
        $display("under three source and sink stall profiles.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[keypad_press_repeat_qualifier] OK");
        end else begin
            $display("[keypad_press_repeat_qualifier] ERROR");
        end
        $finish;
    end

endmodule
